// ----- hw/rtl/etfc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package etfc_pkg;

    // defaults for the top-level parameters
    localparam int DEF_MAX_ITER  = 256;
    localparam int DEF_FRAC_BITS = 60;

    // fixed field widths
    localparam int COORD_W  = 64;
    localparam int CNT_W    = 9;
    localparam int FRAC_W   = 4;
    localparam int COLOUR_W = 24;
    localparam int PADDR_W  = 6;
    localparam int PDATA_W  = 64;

    // register index, byte address / 8
    localparam logic [2:0] REG_JULIA_MODE   = 3'd0;
    localparam logic [2:0] REG_JULIA_C_RE   = 3'd1;
    localparam logic [2:0] REG_JULIA_C_IM   = 3'd2;
    localparam logic [2:0] REG_ALT_PALETTE  = 3'd3;
    localparam logic [2:0] REG_PALETTE_CASE = 3'd4;

    // alternate palette blue rules
    localparam logic [1:0] PAL_DOWN      = 2'd0;
    localparam logic [1:0] PAL_LOW_UP    = 2'd1;
    localparam logic [1:0] PAL_LOW_DOWN  = 2'd2;

    // product selector for the shared multiplier
    localparam logic [1:0] PROD_RE_SQ = 2'd0;
    localparam logic [1:0] PROD_IM_SQ = 2'd1;
    localparam logic [1:0] PROD_CROSS = 2'd2;

    typedef logic [127:0] wide_t;
    typedef logic [63:0]  coord_t;

    function automatic coord_t mag64(coord_t x);
        return x[63] ? (64'd0 - x) : x;
    endfunction

    // signed add clamped to the 64-bit range
    function automatic coord_t sat_add(coord_t a, coord_t b);
        coord_t s;
        s = a + b;
        if ((a[63] == b[63]) && (s[63] != a[63]))
        begin
            s = a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        end
        return s;
    endfunction

    function automatic logic [COLOUR_W-1:0] make_colour(
        logic [CNT_W-1:0]  n,
        logic [FRAC_W-1:0] frac,
        logic              alt,
        logic [1:0]        pcase,
        logic              in_range
    );
        logic [7:0] h;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [5:0] d;
        logic [1:0] sel;
        h     = 8'(n - 9'd1);
        red   = {h[3:0], frac};
        green = {h[5:4], 6'd0};
        blue  = {h[7:6], 6'd0};
        sel   = h[7:6];
        if (alt && (sel != 2'd0) && (green == 8'd0))
        begin
            d     = 6'd63 - red[7:2];
            green = {2'd0, red[7:2]};
            case (pcase)
                PAL_DOWN:
                begin
                    blue = blue - {2'd0, d};
                end
                PAL_LOW_UP:
                begin
                    if (sel == 2'd3)
                        blue = blue - {2'd0, d};
                    else if (sel == 2'd1)
                        blue = blue + {2'd0, d};
                end
                PAL_LOW_DOWN:
                begin
                    if (sel == 2'd3)
                        blue = blue + {2'd0, d};
                    else if (sel == 2'd1)
                        blue = blue - {2'd0, d};
                end
                default:
                begin
                    blue = blue;    // spare variant: swap only
                end
            endcase
            red = 8'd0;
        end
        if (!in_range)
            return '0;
        return {blue, green, red};
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/escape_time_fractal_colour_top.sv -----
// Each iteration step runs S_MAG, S_MUL, S_CHECK and S_DECIDE; a point that escapes after n
//   steps with 0 < n < MAX_ITER then runs S_FPREP and the S_FRAC division, and S_DONE loads
//   the output.
// Throughput: one point at a time; each step runs the single 32x32 multiplier through twelve
//   partial products. Next point is taken while the result word waits.
// Reset: rst_n is asynchronous, active low; clears config registers, sequencer and result valid.
`timescale 1ns / 1ps
`default_nettype none

module escape_time_fractal_colour_top #(
    parameter int MAX_ITER  = etfc_pkg::DEF_MAX_ITER,
    parameter int FRAC_BITS = etfc_pkg::DEF_FRAC_BITS
) (
    input  wire                               clk,
    input  wire                               rst_n,
    // APB-style config port
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire [etfc_pkg::PADDR_W-1:0]       paddr,
    input  wire [etfc_pkg::PDATA_W-1:0]       pwdata,
    output logic [etfc_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready,
    // point channel
    input  wire                               point_valid,
    output logic                              point_stall,
    input  wire signed [etfc_pkg::COORD_W-1:0] point_re,
    input  wire signed [etfc_pkg::COORD_W-1:0] point_im,
    // result channel
    output logic                              result_valid,
    input  wire                               result_stall,
    output logic [etfc_pkg::CNT_W-1:0]        iter_count,
    output logic [etfc_pkg::FRAC_W-1:0]       smooth_fraction,
    output logic [etfc_pkg::COLOUR_W-1:0]     pixel_colour
);

    // ------------------------------------------------------------------
    // Constants
    // ------------------------------------------------------------------
    localparam logic [etfc_pkg::CNT_W-1:0] MAX_N = etfc_pkg::CNT_W'(MAX_ITER);
    // 4.0 at 2*FRAC_BITS fraction bits, the escape threshold for |z|^2
    localparam etfc_pkg::wide_t FOUR = 128'(1) << (2 * FRAC_BITS + 2);
    // 3 products x 4 partials; one extra step drains the product register
    localparam logic [3:0] MUL_LAST = 4'd12;

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;   // waiting for a point word
    localparam logic [2:0] S_MAG    = 3'd1;   // magnitudes and product sign of z
    localparam logic [2:0] S_MUL    = 3'd2;   // partial products through the multiplier
    localparam logic [2:0] S_CHECK  = 3'd3;   // |z|^2, re^2-im^2, signed re*im
    localparam logic [2:0] S_DECIDE = 3'd4;   // escape test or z update
    localparam logic [2:0] S_FPREP  = 3'd5;   // numerator and denominator of fraction
    localparam logic [2:0] S_FRAC   = 3'd6;   // division by repeated subtraction, frac counts the quotient
    localparam logic [2:0] S_DONE   = 3'd7;   // hand result to the output register

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    logic                      julia_mode_reg;
    etfc_pkg::coord_t          julia_c_re_reg;
    etfc_pkg::coord_t          julia_c_im_reg;
    logic                      alt_palette_reg;
    logic [1:0]                palette_case_reg;
    logic                      cfg_write;
    logic [2:0]                cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            julia_mode_reg   <= 1'b0;
            julia_c_re_reg   <= '0;
            julia_c_im_reg   <= '0;
            alt_palette_reg  <= 1'b0;
            palette_case_reg <= 2'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                etfc_pkg::REG_JULIA_MODE:   julia_mode_reg   <= pwdata[0];
                etfc_pkg::REG_JULIA_C_RE:   julia_c_re_reg   <= pwdata;
                etfc_pkg::REG_JULIA_C_IM:   julia_c_im_reg   <= pwdata;
                etfc_pkg::REG_ALT_PALETTE:  alt_palette_reg  <= pwdata[0];
                etfc_pkg::REG_PALETTE_CASE: palette_case_reg <= pwdata[1:0];
                default:
                begin
                    // unmapped index: dropped
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            etfc_pkg::REG_JULIA_MODE:   prdata = {63'd0, julia_mode_reg};
            etfc_pkg::REG_JULIA_C_RE:   prdata = julia_c_re_reg;
            etfc_pkg::REG_JULIA_C_IM:   prdata = julia_c_im_reg;
            etfc_pkg::REG_ALT_PALETTE:  prdata = {63'd0, alt_palette_reg};
            etfc_pkg::REG_PALETTE_CASE: prdata = {62'd0, palette_case_reg};
            default:                    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer and datapath registers
    // ------------------------------------------------------------------
    logic [2:0]                     state_reg, state_next;
    logic [3:0]                     step_reg, step_next;
    logic                           pp_valid_reg, pp_valid_next;
    logic                           result_valid_reg, result_valid_next;

    etfc_pkg::coord_t               zr_reg, zr_next;     // z, Q.FRAC_BITS
    etfc_pkg::coord_t               zi_reg, zi_next;
    etfc_pkg::coord_t               cr_reg, cr_next;     // c
    etfc_pkg::coord_t               ci_reg, ci_next;
    etfc_pkg::coord_t               mr_reg, mr_next;     // |re|, |im|
    etfc_pkg::coord_t               mi_reg, mi_next;
    logic                           sgn_reg, sgn_next;   // sign of re*im
    logic [63:0]                    pp_reg, pp_next;     // partial product
    logic [1:0]                     pp_tag_reg, pp_tag_next;
    logic [1:0]                     pp_sh_reg, pp_sh_next; // offset in 32-bit words
    etfc_pkg::wide_t                sq_re_reg, sq_re_next;
    etfc_pkg::wide_t                sq_im_reg, sq_im_next;
    etfc_pkg::wide_t                prod_reg, prod_next;
    etfc_pkg::wide_t                fin_reg, fin_next;   // |z|^2
    etfc_pkg::wide_t                diff_reg, diff_next; // re^2 - im^2
    etfc_pkg::wide_t                ps_reg, ps_next;     // signed re*im
    etfc_pkg::wide_t                last_reg, last_next; // last |z|^2 inside radius
    etfc_pkg::wide_t                num_reg, num_next;
    etfc_pkg::wide_t                den_reg, den_next;
    logic [etfc_pkg::CNT_W-1:0]     n_reg, n_next;
    logic [etfc_pkg::FRAC_W-1:0]    frac_reg, frac_next;
    logic [etfc_pkg::CNT_W-1:0]     iter_count_reg, iter_count_next;
    logic [etfc_pkg::FRAC_W-1:0]    smooth_fraction_reg, smooth_fraction_next;
    logic [etfc_pkg::COLOUR_W-1:0]  pixel_colour_reg, pixel_colour_next;

    // shared multiplier operands
    logic [1:0]                     mul_sel;
    etfc_pkg::coord_t               mul_a_word, mul_b_word;
    logic [31:0]                    mul_a, mul_b;
    logic [63:0]                    mul_p;
    // shared accumulator adder
    etfc_pkg::wide_t                acc_cur, acc_add, acc_sum;
    // update and division helpers
    etfc_pkg::wide_t                tr_wide, ti_wide;
    logic [128:0]                   div_sub;
    logic                           escape;
    logic                           in_range;
    logic                           point_take;
    logic                           result_take;

    assign point_take  = point_valid && !point_stall;
    assign result_take = result_valid_reg && !result_stall;

    // operands: step[3:2] picks the product, step[0]/step[1] the halves
    assign mul_sel    = step_reg[3:2];
    assign mul_a_word = (mul_sel == etfc_pkg::PROD_IM_SQ) ? mi_reg : mr_reg;
    assign mul_b_word = (mul_sel == etfc_pkg::PROD_RE_SQ) ? mr_reg : mi_reg;
    assign mul_a      = step_reg[0] ? mul_a_word[63:32] : mul_a_word[31:0];
    assign mul_b      = step_reg[1] ? mul_b_word[63:32] : mul_b_word[31:0];
    assign mul_p      = 64'(mul_a) * 64'(mul_b);

    always_comb
    begin
        case (pp_tag_reg)
            etfc_pkg::PROD_RE_SQ: acc_cur = sq_re_reg;
            etfc_pkg::PROD_IM_SQ: acc_cur = sq_im_reg;
            default:              acc_cur = prod_reg;
        endcase
        case (pp_sh_reg)
            2'd0:    acc_add = {64'd0, pp_reg};
            2'd1:    acc_add = {32'd0, pp_reg, 32'd0};
            default: acc_add = {pp_reg, 64'd0};
        endcase
        acc_sum = acc_cur + acc_add;
    end

    // Re(z^2) and Im(z^2) back at FRAC_BITS, floor rounding
    assign tr_wide  = diff_reg >> FRAC_BITS;
    assign ti_wide  = ps_reg >> (FRAC_BITS - 1);
    assign escape   = (fin_reg > FOUR) || (n_reg >= MAX_N);
    assign div_sub  = {1'b0, num_reg} - {1'b0, den_reg};
    assign in_range = (n_reg != '0) && (n_reg < MAX_N);

    always_comb
    begin
        state_next           = state_reg;
        step_next            = step_reg;
        pp_valid_next        = 1'b0;
        result_valid_next    = result_take ? 1'b0 : result_valid_reg;
        zr_next              = zr_reg;
        zi_next              = zi_reg;
        cr_next              = cr_reg;
        ci_next              = ci_reg;
        mr_next              = mr_reg;
        mi_next              = mi_reg;
        sgn_next             = sgn_reg;
        pp_next              = pp_reg;
        pp_tag_next          = pp_tag_reg;
        pp_sh_next           = pp_sh_reg;
        sq_re_next           = sq_re_reg;
        sq_im_next           = sq_im_reg;
        prod_next            = prod_reg;
        fin_next             = fin_reg;
        diff_next            = diff_reg;
        ps_next              = ps_reg;
        last_next            = last_reg;
        num_next             = num_reg;
        den_next             = den_reg;
        n_next               = n_reg;
        frac_next            = frac_reg;
        iter_count_next      = iter_count_reg;
        smooth_fraction_next = smooth_fraction_reg;
        pixel_colour_next    = pixel_colour_reg;

        // partial products are registered in pp_reg and land in the selected accumulator in the following cycle
        if (pp_valid_reg)
        begin
            case (pp_tag_reg)
                etfc_pkg::PROD_RE_SQ: sq_re_next = acc_sum;
                etfc_pkg::PROD_IM_SQ: sq_im_next = acc_sum;
                default:              prod_next  = acc_sum;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (point_valid)
                begin
                    zr_next    = point_re;
                    zi_next    = point_im;
                    cr_next    = julia_mode_reg ? julia_c_re_reg : point_re;
                    ci_next    = julia_mode_reg ? julia_c_im_reg : point_im;
                    last_next  = '0;
                    n_next     = '0;
                    frac_next  = '0;
                    state_next = S_MAG;
                end
            end
            S_MAG:
            begin
                mr_next    = etfc_pkg::mag64(zr_reg);
                mi_next    = etfc_pkg::mag64(zi_reg);
                sgn_next   = zr_reg[63] ^ zi_reg[63];
                sq_re_next = '0;
                sq_im_next = '0;
                prod_next  = '0;
                step_next  = 4'd0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (step_reg == MUL_LAST)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    pp_next       = mul_p;
                    pp_tag_next   = mul_sel;
                    pp_sh_next    = 2'(step_reg[0]) + 2'(step_reg[1]);
                    pp_valid_next = 1'b1;
                    step_next     = step_reg + 4'd1;
                end
            end
            S_CHECK:
            begin
                fin_next   = sq_re_reg + sq_im_reg;
                diff_next  = sq_re_reg - sq_im_reg;
                ps_next    = sgn_reg ? (128'd0 - prod_reg) : prod_reg;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (escape)
                begin
                    state_next = in_range ? S_FPREP : S_DONE;
                end
                else
                begin
                    zr_next    = etfc_pkg::sat_add(tr_wide[63:0], cr_reg);
                    zi_next    = etfc_pkg::sat_add(ti_wide[63:0], ci_reg);
                    last_next  = fin_reg;
                    n_next     = n_reg + 9'd1;
                    state_next = S_MAG;
                end
            end
            S_FPREP:
            begin
                // 16*(4 - last) over (final - last)
                num_next   = (FOUR - last_reg) << 4;
                den_next   = fin_reg - last_reg;
                state_next = S_FRAC;
            end
            S_FRAC:
            begin
                if ((frac_reg == 4'd15) || div_sub[128])
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    num_next  = div_sub[127:0];
                    frac_next = frac_reg + 4'd1;
                end
            end
            S_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    iter_count_next      = n_reg;
                    smooth_fraction_next = frac_reg;
                    pixel_colour_next    = etfc_pkg::make_colour(n_reg, frac_reg,
                                               alt_palette_reg, palette_case_reg, in_range);
                    result_valid_next    = 1'b1;
                    state_next           = S_IDLE;
                end
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            step_reg         <= 4'd0;
            pp_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            pp_valid_reg     <= pp_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        zr_reg              <= zr_next;
        zi_reg              <= zi_next;
        cr_reg              <= cr_next;
        ci_reg              <= ci_next;
        mr_reg              <= mr_next;
        mi_reg              <= mi_next;
        sgn_reg             <= sgn_next;
        pp_reg              <= pp_next;
        pp_tag_reg          <= pp_tag_next;
        pp_sh_reg           <= pp_sh_next;
        sq_re_reg           <= sq_re_next;
        sq_im_reg           <= sq_im_next;
        prod_reg            <= prod_next;
        fin_reg             <= fin_next;
        diff_reg            <= diff_next;
        ps_reg              <= ps_next;
        last_reg            <= last_next;
        num_reg             <= num_next;
        den_reg             <= den_next;
        n_reg               <= n_next;
        frac_reg            <= frac_next;
        iter_count_reg      <= iter_count_next;
        smooth_fraction_reg <= smooth_fraction_next;
        pixel_colour_reg    <= pixel_colour_next;
    end

    assign point_stall     = (state_reg != S_IDLE);
    assign result_valid    = result_valid_reg;
    assign iter_count      = iter_count_reg;
    assign smooth_fraction = smooth_fraction_reg;
    assign pixel_colour    = pixel_colour_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // an accepted point word starts the first magnitude step
    a_take_starts: assert property (@(posedge clk) disable iff (!rst_n)
        point_take |=> (state_reg == S_MAG))
        else $error("accepted point did not start iteration");

    // iteration count never passes the limit
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (iter_count <= MAX_N))
        else $error("iteration count beyond limit");

    // black and zero fraction for immediate escape or no escape
    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && ((iter_count == '0) || (iter_count == MAX_N)))
            |-> ((smooth_fraction == '0) && (pixel_colour == '0)))
        else $error("nonzero fraction or colour at count 0 or limit");

    // the multiplier is only fed while partial products are stepping
    a_mul_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
        pp_valid_reg |-> ($past(state_reg) == S_MUL))
        else $error("partial product outside multiply phase");

endmodule

`default_nettype wire

// ----- verif/etfc_checker.sv -----
`timescale 1ns / 1ps

module etfc_checker (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire                                pready,
    input  wire [etfc_pkg::PADDR_W-1:0]        paddr,
    input  wire [etfc_pkg::PDATA_W-1:0]        pwdata,
    input  wire                                point_valid,
    input  wire                                point_stall,
    input  wire [etfc_pkg::COORD_W-1:0]        point_re,
    input  wire [etfc_pkg::COORD_W-1:0]        point_im,
    input  wire                                result_valid,
    input  wire                                result_stall,
    input  wire [etfc_pkg::CNT_W-1:0]          iter_count,
    input  wire [etfc_pkg::FRAC_W-1:0]         smooth_fraction,
    input  wire [etfc_pkg::COLOUR_W-1:0]       pixel_colour,
    output int                                 errors,
    output int                                 outstanding
);

    localparam int MAX_ITER   = etfc_pkg::DEF_MAX_ITER;
    localparam int FB         = etfc_pkg::DEF_FRAC_BITS;
    localparam int REPORT_CAP = 100;

    localparam etfc_pkg::coord_t Q_TOP    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam etfc_pkg::coord_t Q_BOTTOM = 64'h8000_0000_0000_0000;
    localparam logic [127:0]     RADIUS_SQ = 128'd1 << (2 * FB + 2);   // 4.0 at 2*FB

    typedef struct packed {
        logic [etfc_pkg::CNT_W-1:0]    count;
        logic [etfc_pkg::FRAC_W-1:0]   frac;
        logic [etfc_pkg::COLOUR_W-1:0] colour;
    } pixel_t;

    // register shadow, tracked off the config bus
    logic                julia_on;
    etfc_pkg::coord_t    julia_re;
    etfc_pkg::coord_t    julia_im;
    logic                alt_on;
    logic [1:0]          pal_rule;

    pixel_t              expected_pixels[$];
    int                  fails;

    function automatic etfc_pkg::coord_t abs64(etfc_pkg::coord_t a);
        return a[63] ? (~a + 64'd1) : a;
    endfunction

    function automatic etfc_pkg::coord_t clamp_add(etfc_pkg::coord_t a, etfc_pkg::coord_t b);
        logic signed [64:0] s;
        s = $signed({a[63], a}) + $signed({b[63], b});
        if (s[64] != s[63])
            return s[64] ? Q_BOTTOM : Q_TOP;
        return s[63:0];
    endfunction

    function automatic logic [23:0] tint(int unsigned n, logic [3:0] frac);
        logic [11:0] v;
        logic [7:0]  h;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  d;
        logic [1:0]  band;
        if (n == 0 || n >= MAX_ITER)
            return '0;
        v     = 12'(frac) + 12'((n - 1) * 16);
        h     = v[11:4];
        red   = v[7:0];
        green = (h & 8'd48) << 2;
        blue  = h & 8'd192;
        band  = blue[7:6];
        if (alt_on && band != 2'd0 && green == 8'd0)
        begin
            d     = 8'd63 - (red >> 2);
            green = red >> 2;
            case (pal_rule)
                etfc_pkg::PAL_DOWN:
                begin
                    blue = blue - d;
                end
                etfc_pkg::PAL_LOW_UP:
                begin
                    if (band == 2'd3)
                        blue = blue - d;
                    else if (band == 2'd1)
                        blue = blue + d;
                end
                etfc_pkg::PAL_LOW_DOWN:
                begin
                    if (band == 2'd3)
                        blue = blue + d;
                    else if (band == 2'd1)
                        blue = blue - d;
                end
                default:
                begin
                end
            endcase
            red = 8'd0;
        end
        return {blue, green, red};
    endfunction

    // escape-time count, smoothing sixteenths and colour for one point
    function automatic pixel_t escape_time(etfc_pkg::coord_t pre, etfc_pkg::coord_t pim);
        etfc_pkg::coord_t    zr;
        etfc_pkg::coord_t    zi;
        etfc_pkg::coord_t    cr;
        etfc_pkg::coord_t    ci;
        etfc_pkg::coord_t    ar;
        etfc_pkg::coord_t    ai;
        logic [127:0]        sq_re;
        logic [127:0]        sq_im;
        logic [127:0]        mod2;
        logic [127:0]        prev;
        logic [127:0]        diff;
        logic [127:0]        num;
        logic [127:0]        den;
        logic signed [127:0] wr;
        logic signed [127:0] wi;
        logic signed [127:0] xprod;
        int unsigned         steps;
        logic [3:0]          frac;
        pixel_t              px;
        zr    = pre;
        zi    = pim;
        cr    = julia_on ? julia_re : pre;
        ci    = julia_on ? julia_im : pim;
        prev  = '0;
        steps = 0;
        frac  = 4'd0;
        forever
        begin
            ar    = abs64(zr);
            ai    = abs64(zi);
            sq_re = {64'd0, ar} * {64'd0, ar};
            sq_im = {64'd0, ai} * {64'd0, ai};
            mod2  = sq_re + sq_im;
            if (mod2 > RADIUS_SQ || steps >= MAX_ITER)
                break;
            prev  = mod2;
            diff  = sq_re - sq_im;
            wr    = $signed(zr);
            wi    = $signed(zi);
            xprod = wr * wi;
            zr    = clamp_add(diff[FB+63:FB], cr);
            zi    = clamp_add(xprod[FB+62:FB-1], ci);
            steps++;
        end
        if (steps > 0 && steps < MAX_ITER)
        begin
            num = (RADIUS_SQ - prev) << 4;
            den = mod2 - prev;
            while (frac < 4'd15 && !(den > num))
            begin
                num = num - den;
                frac++;
            end
        end
        px.count  = etfc_pkg::CNT_W'(steps);
        px.frac   = frac;
        px.colour = tint(steps, frac);
        return px;
    endfunction

    task automatic report_miss(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        fails++;
        if (fails <= REPORT_CAP)
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
        else if (fails == REPORT_CAP + 1)
            $display("%0t ns: further mismatches counted but not shown", $time);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        if (!rst_n)
        begin
            julia_on    <= 1'b0;
            julia_re    <= '0;
            julia_im    <= '0;
            alt_on      <= 1'b0;
            pal_rule    <= 2'd0;
            expected_pixels.delete();
            fails       = 0;
            errors      <= 0;
            outstanding <= 0;
        end
        else
        begin
            // retire before queuing so a word never matches a point taken this edge
            if (result_valid && !result_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    report_miss("unrequested word", 64'd0,
                                64'({iter_count, smooth_fraction, pixel_colour}));
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (iter_count !== want.count)
                        report_miss("iter_count", 64'(want.count), 64'(iter_count));
                    if (smooth_fraction !== want.frac)
                        report_miss("smooth_fraction", 64'(want.frac), 64'(smooth_fraction));
                    if (pixel_colour !== want.colour)
                        report_miss("pixel_colour", 64'(want.colour), 64'(pixel_colour));
                end
            end
            if (point_valid && !point_stall)
                expected_pixels.push_back(escape_time(point_re, point_im));
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[etfc_pkg::PADDR_W-1:3])
                    etfc_pkg::REG_JULIA_MODE:   julia_on <= pwdata[0];
                    etfc_pkg::REG_JULIA_C_RE:   julia_re <= pwdata;
                    etfc_pkg::REG_JULIA_C_IM:   julia_im <= pwdata;
                    etfc_pkg::REG_ALT_PALETTE:  alt_on   <= pwdata[0];
                    etfc_pkg::REG_PALETTE_CASE: pal_rule <= pwdata[1:0];
                    default:
                    begin
                    end
                endcase
            end
            errors      <= fails;
            outstanding <= expected_pixels.size();
        end
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    // Q4.60 constants
    localparam etfc_pkg::coord_t Q_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam etfc_pkg::coord_t Q_MIN   = 64'h8000_0000_0000_0000;
    localparam etfc_pkg::coord_t ONE     = 64'h1000_0000_0000_0000;
    localparam etfc_pkg::coord_t TWO     = 64'h2000_0000_0000_0000;
    localparam etfc_pkg::coord_t HALF    = 64'h0800_0000_0000_0000;
    localparam etfc_pkg::coord_t QUARTER = 64'h0400_0000_0000_0000;
    localparam etfc_pkg::coord_t NECK    = 64'hF400_0000_0000_0000;   // -0.75

    localparam int PADDR_W = etfc_pkg::PADDR_W;
    localparam int PDATA_W = etfc_pkg::PDATA_W;

    // register slot past the last real one; writes there must do nothing
    localparam logic [2:0] REG_SPARE = 3'd5;
    // fourth palette code: red/green swap with blue untouched
    localparam logic [1:0] PAL_SPARE = 2'd3;

    // Worst case per point: a full 256-step orbit, then the divide and output
    // load, plus the longest point gap and result stall. 1828 points in total,
    // rounded up to 1950, then four times over.
    localparam int CYCLE_LIMIT = 4 * 1950 * (16 * (etfc_pkg::DEF_MAX_ITER + 1) + 40);

    logic                              clk;
    logic                              rst_n;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [PADDR_W-1:0]                paddr;
    logic [PDATA_W-1:0]                pwdata;
    logic [PDATA_W-1:0]                prdata;
    logic                              pready;
    logic                              point_valid;
    logic                              point_stall;
    etfc_pkg::coord_t                  point_re;
    etfc_pkg::coord_t                  point_im;
    logic                              result_valid;
    logic                              result_stall;
    logic [etfc_pkg::CNT_W-1:0]        iter_count;
    logic [etfc_pkg::FRAC_W-1:0]       smooth_fraction;
    logic [etfc_pkg::COLOUR_W-1:0]     pixel_colour;

    int                   errors;
    int                   outstanding;

    // idle odds in percent, per word on the point side, per cycle on the result side
    int                   gap_pct;
    int                   stall_pct;
    int                   points_sent;
    int                   settings_done;
    int unsigned          cycle_count;

    escape_time_fractal_colour_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .point_valid     (point_valid),
        .point_stall     (point_stall),
        .point_re        (point_re),
        .point_im        (point_im),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .iter_count      (iter_count),
        .smooth_fraction (smooth_fraction),
        .pixel_colour    (pixel_colour)
    );

    // the checker watches both channels and the config bus on its own
    etfc_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .point_valid     (point_valid),
        .point_stall     (point_stall),
        .point_re        (point_re),
        .point_im        (point_im),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .iter_count      (iter_count),
        .smooth_fraction (smooth_fraction),
        .pixel_colour    (pixel_colour),
        .errors          (errors),
        .outstanding     (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hang guard
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top: errors");
        $finish;
    end

    // result-side backpressure: random bursts of stalled cycles
    initial
    begin
        result_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ($urandom_range(99) < stall_pct)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    function automatic etfc_pkg::coord_t to_q(real r);
        return etfc_pkg::coord_t'(longint'(r * 1152921504606846976.0));
    endfunction

    // full random word, sign-extended down by shift (range +-8 / 2^shift)
    function automatic etfc_pkg::coord_t rand_q(int unsigned shift);
        etfc_pkg::coord_t raw;
        raw = {$urandom, $urandom};
        return $signed(raw) >>> shift;
    endfunction

    // two-phase config write; the bus returns idle after it so writes never abut
    task automatic reg_write(input logic [2:0] idx, input logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 3'b000});
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Present one point word and hold it until taken. An optional gap
    // drops valid first; with no gap valid simply stays high.
    task automatic send_point(input etfc_pkg::coord_t re, input etfc_pkg::coord_t im);
        if ($urandom_range(99) < gap_pct)
        begin
            point_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        point_valid <= 1'b1;
        point_re    <= re;
        point_im    <= im;
        @(posedge clk);
        while (point_stall) @(posedge clk);
        points_sent++;
    endtask

    // Stop sending and wait for every pending word to come back. The first
    // edge lets the checker count the last point taken.
    task automatic settle();
        point_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    // Random point mix:
    //   20% any bit pattern (most escape at once, covers every input bit)
    //   50% the box around the set, where most of the counts land
    //   15% slow-escape spots: near the cusp at 1/4 and across the neck
    //       at -3/4 (Mandelbrot), or close to the origin (Julia)
    //   15% right on the escape radius
    task automatic pick_point(input bit julia, output etfc_pkg::coord_t re,
                              output etfc_pkg::coord_t im);
        int unsigned      roll;
        etfc_pkg::coord_t tmp;
        roll = $urandom_range(99);
        if (roll < 20)
        begin
            re = {$urandom, $urandom};
            im = {$urandom, $urandom};
        end
        else if (roll < 70)
        begin
            re = rand_q(2);
            im = rand_q(2);
            if (!julia)
                re = re - HALF;
        end
        else if (roll < 85)
        begin
            if (julia)
            begin
                re = rand_q(4);
                im = rand_q(4);
            end
            else if ($urandom_range(1) == 0)
            begin
                // 1/4 + eps, eps in about [2^-13, 2^-8]: counts ~50 up to never
                re = QUARTER + (etfc_pkg::coord_t'(1) << 47)
                     + (rand_q(0) & ((etfc_pkg::coord_t'(1) << 52) - 1));
                im = rand_q(16);
            end
            else
            begin
                // count goes roughly as pi / |im| through the neck
                re = NECK + rand_q(20);
                im = to_q(0.0125) + (rand_q(0) & ((etfc_pkg::coord_t'(1) << 55) - 1));
                if ($urandom_range(1) == 0)
                    im = -im;
            end
        end
        else
        begin
            re = (($urandom_range(1) == 0) ? TWO : -TWO) + rand_q(24);
            im = rand_q(24);
            if ($urandom_range(1) == 0)
            begin
                tmp = re;
                re  = im;
                im  = tmp;
            end
        end
    endtask

    task automatic run_batch(input int count, input bit julia);
        etfc_pkg::coord_t re;
        etfc_pkg::coord_t im;
        repeat (count)
        begin
            pick_point(julia, re, im);
            send_point(re, im);
        end
        settle();
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        point_valid   <= 1'b0;
        point_re      <= '0;
        point_im      <= '0;
        gap_pct       = 20;
        stall_pct     = 10;
        points_sent   = 0;
        settings_done = 1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed, reset config: Mandelbrot, plain palette ----
        send_point('0, '0);                         // never escapes
        send_point(Q_MAX, Q_MAX);                   // gone before the first step
        send_point(Q_MIN, Q_MIN);                   // largest magnitudes
        send_point(Q_MAX, Q_MIN);
        send_point(Q_MIN, '0);
        send_point('0, Q_MAX);
        send_point(TWO, '0);                        // |z|^2 exactly 4, then out: fraction 0
        send_point(-TWO, '0);                       // sits on radius 2 forever
        send_point('0, TWO);
        send_point(-TWO - 64'd1, '0);               // one lsb past the radius
        send_point(QUARTER, '0);                    // cusp: converges, never escapes
        send_point(to_q(0.26), '0);
        send_point(QUARTER + (etfc_pkg::coord_t'(1) << 50), '0);
        send_point(NECK, to_q(0.02));
        send_point(NECK, to_q(-0.05));
        send_point(to_q(0.3), to_q(0.5));
        send_point(to_q(-1.5), to_q(0.5));
        send_point(to_q(-0.1), to_q(0.9));
        settle();

        // ---- alternate palette, each blue rule in turn ----
        reg_write(etfc_pkg::REG_ALT_PALETTE, PDATA_W'(1));
        reg_write(etfc_pkg::REG_PALETTE_CASE, PDATA_W'(etfc_pkg::PAL_DOWN));
        reg_write(REG_SPARE, '1);                   // must not disturb anything
        settings_done++;
        gap_pct   = 30;
        stall_pct = 15;
        run_batch(300, 1'b0);

        reg_write(etfc_pkg::REG_PALETTE_CASE, PDATA_W'(etfc_pkg::PAL_LOW_UP));
        settings_done++;
        gap_pct   = 10;
        stall_pct = 30;
        run_batch(300, 1'b0);

        reg_write(etfc_pkg::REG_PALETTE_CASE, PDATA_W'(etfc_pkg::PAL_LOW_DOWN));
        settings_done++;
        gap_pct   = 50;
        stall_pct = 5;
        run_batch(300, 1'b0);

        // spare rule, and a stretch with no idling at all
        reg_write(etfc_pkg::REG_PALETTE_CASE, PDATA_W'(PAL_SPARE));
        settings_done++;
        gap_pct   = 0;
        stall_pct = 0;
        run_batch(200, 1'b0);

        // ---- Julia with extreme constants: saturating adds ----
        reg_write(etfc_pkg::REG_ALT_PALETTE, PDATA_W'(0));
        reg_write(etfc_pkg::REG_JULIA_MODE, PDATA_W'(1));
        reg_write(etfc_pkg::REG_JULIA_C_RE, Q_MAX);
        reg_write(etfc_pkg::REG_JULIA_C_IM, Q_MIN);
        settings_done++;
        gap_pct   = 20;
        stall_pct = 10;
        send_point('0, '0);
        send_point(TWO, '0);                        // 4 + max clips high
        send_point('0, TWO);                        // imag: 0 + min
        send_point(to_q(1.4), to_q(1.4));
        settle();

        reg_write(etfc_pkg::REG_JULIA_C_RE, Q_MIN);
        reg_write(etfc_pkg::REG_JULIA_C_IM, Q_MAX);
        settings_done++;
        send_point('0, TWO);                        // -4 + min clips low
        send_point(to_q(1.4), to_q(1.4));           // 2*re*im + max clips high
        send_point(TWO, '0);
        settle();

        // c = 0: the unit circle is the boundary
        reg_write(etfc_pkg::REG_JULIA_C_RE, '0);
        reg_write(etfc_pkg::REG_JULIA_C_IM, '0);
        settings_done++;
        send_point(ONE, '0);
        send_point('0, -ONE);
        send_point(ONE + 64'd1, '0);                // creeps out over ~60 steps
        settle();

        // ---- Julia, c just outside the set in the neck ----
        reg_write(etfc_pkg::REG_ALT_PALETTE, PDATA_W'(1));
        reg_write(etfc_pkg::REG_PALETTE_CASE, PDATA_W'(etfc_pkg::PAL_LOW_UP));
        reg_write(etfc_pkg::REG_JULIA_C_RE, NECK);
        reg_write(etfc_pkg::REG_JULIA_C_IM, to_q(0.06));
        settings_done++;
        gap_pct   = 30;
        stall_pct = 15;
        run_batch(300, 1'b1);

        // ---- Julia, random c above or below the set so every orbit escapes ----
        reg_write(etfc_pkg::REG_PALETTE_CASE, PDATA_W'(etfc_pkg::PAL_LOW_DOWN));
        repeat (4)
        begin
            reg_write(etfc_pkg::REG_JULIA_C_RE, rand_q(2));
            reg_write(etfc_pkg::REG_JULIA_C_IM,
                      (($urandom_range(1) == 0) ? 64'd0 : 64'd1) == 0
                      ? to_q(1.2) + (rand_q(0) & ((etfc_pkg::coord_t'(1) << 59) - 1))
                      : -(to_q(1.2) + (rand_q(0) & ((etfc_pkg::coord_t'(1) << 59) - 1))));
            settings_done++;
            gap_pct   = 20;
            stall_pct = 20;
            run_batch(50, 1'b1);
        end

        // ---- closing stretch: Mandelbrot, plain palette, no idling ----
        reg_write(etfc_pkg::REG_JULIA_MODE, PDATA_W'(0));
        reg_write(etfc_pkg::REG_ALT_PALETTE, PDATA_W'(0));
        settings_done++;
        gap_pct   = 0;
        stall_pct = 0;
        run_batch(200, 1'b0);

        // any stray word would show up here
        repeat (300) @(posedge clk);

        $display("summary: %0d points over %0d register settings", points_sent, settings_done);
        $display("summary: Mandelbrot and Julia, all palette rules, saturating constants");
        if (errors == 0 && outstanding == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
